// ===== design/mtes_pkg.sv =====
`timescale 1ns / 1ps

package mtes_pkg;

  localparam int CHANNELS      = 12;
  localparam int RECORD_LENGTH = 1024;

  localparam int HEIGHT_W = 16;
  localparam int PEAK_W   = 15;
  localparam int POS_W    = 10;
  localparam int CNT_W    = 4;
  localparam int NSQ_W    = 2 * CNT_W;
  localparam int SUM_W    = 14;
  localparam int SQSUM_W  = 24;
  localparam int MULT_W   = 3;
  localparam int LIMIT_W  = 12;
  localparam int PROD_W   = CNT_W + SQSUM_W;
  localparam int LIMPROD_W = LIMIT_W + NSQ_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CNT_W-1:0]   MIN_HITS_RST     = CNT_W'(3);
  localparam logic [MULT_W-1:0]  PE_MULTIPLE_RST  = MULT_W'(2);
  localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RST = LIMIT_W'(25);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_HITS     = 2'd0,
    CFG_PE_MULTIPLE  = 2'd1,
    CFG_SPREAD_LIMIT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_REJECT = 2'd0,
    VERDICT_GOOD   = 2'd1,
    VERDICT_BAD    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] pulse_height;
    logic [PEAK_W-1:0]          one_pe_peak;
    logic [POS_W-1:0]           peak_position;
    logic                       last_channel;
  } in_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [CNT_W-1:0] hit_count;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   n;
    logic [NSQ_W-1:0]   n_sq;
    logic [SUM_W-1:0]   s1;
    logic [SQSUM_W-1:0] s2;
  } event_t;

endpackage

// ===== design/mtes_accum.sv =====
`timescale 1ns / 1ps

module mtes_accum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  mtes_pkg::in_t                     item,
  input  logic [mtes_pkg::MULT_W-1:0]       pe_multiple,
  output mtes_pkg::event_t                  totals
);

  localparam int THR_W = mtes_pkg::MULT_W + mtes_pkg::PEAK_W;

  logic [mtes_pkg::CNT_W-1:0]   hits_r, hits_nxt;
  logic [mtes_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [mtes_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [mtes_pkg::SQSUM_W-1:0] sq_sum_r, sq_sum_nxt;

  logic [THR_W-1:0]             threshold;
  logic                         hit;
  logic                         take;
  logic [mtes_pkg::POS_W-1:0]   pos;
  logic [2*mtes_pkg::POS_W-1:0] pos_sq;
  logic [mtes_pkg::CNT_W-1:0]   hits_upd, count_upd;
  logic [mtes_pkg::SUM_W-1:0]   sum_upd;
  logic [mtes_pkg::SQSUM_W-1:0] sq_sum_upd;

  always_comb begin
    threshold = THR_W'(pe_multiple) * THR_W'(item.one_pe_peak);
    hit = $signed({{(THR_W + 1 - mtes_pkg::HEIGHT_W){item.pulse_height[mtes_pkg::HEIGHT_W-1]}},
                   item.pulse_height}) > $signed({1'b0, threshold});
    take = count_r < mtes_pkg::CNT_W'(mtes_pkg::CHANNELS);
    // clamp positions past the record end
    if (int'(item.peak_position) >= mtes_pkg::RECORD_LENGTH) begin
      pos = mtes_pkg::POS_W'(mtes_pkg::RECORD_LENGTH - 1);
    end else begin
      pos = item.peak_position;
    end
    pos_sq = (2*mtes_pkg::POS_W)'(pos) * (2*mtes_pkg::POS_W)'(pos);

    hits_upd   = hits_r;
    count_upd  = count_r;
    sum_upd    = sum_r;
    sq_sum_upd = sq_sum_r;
    if (take) begin
      if (hit) begin
        hits_upd = hits_r + mtes_pkg::CNT_W'(1);
      end
      count_upd  = count_r + mtes_pkg::CNT_W'(1);
      sum_upd    = sum_r + mtes_pkg::SUM_W'(pos);
      sq_sum_upd = sq_sum_r + mtes_pkg::SQSUM_W'(pos_sq);
    end

    totals.hits = hits_upd;
    totals.n    = count_upd;
    totals.n_sq = mtes_pkg::NSQ_W'(count_upd) * mtes_pkg::NSQ_W'(count_upd);
    totals.s1   = sum_upd;
    totals.s2   = sq_sum_upd;
  end

  always_comb begin
    hits_nxt   = hits_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    sq_sum_nxt = sq_sum_r;
    if (accept) begin
      if (item.last_channel) begin
        hits_nxt   = '0;
        count_nxt  = '0;
        sum_nxt    = '0;
        sq_sum_nxt = '0;
      end else begin
        hits_nxt   = hits_upd;
        count_nxt  = count_upd;
        sum_nxt    = sum_upd;
        sq_sum_nxt = sq_sum_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      count_r  <= '0;
      sum_r    <= '0;
      sq_sum_r <= '0;
    end else begin
      hits_r   <= hits_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      sq_sum_r <= sq_sum_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.last_channel |=> count_r == '0 && hits_r == '0 && sum_r == '0)
    else $error("accumulators not cleared after last channel");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mtes_pkg::CNT_W'(mtes_pkg::CHANNELS) && hits_r <= count_r)
    else $error("channel or hit count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r) && $stable(sq_sum_r))
    else $error("accumulator moved without a transfer");
`endif

endmodule

// ===== design/multiplicity_timing_event_select.sv =====
`timescale 1ns / 1ps

// Event qualifier: takes one channel per cycle while the input is not stalled, counts
// channels above pe_multiple times their single-photoelectron peak and accumulates
// peak-position sums, and on each last-channel transfer issues one verdict (rejected,
// good or bad timing) with the hit count. A channel enters whenever the input is not
// stalled; the verdict of an event moves through the variance pipeline (event capture
// register, product register, then subtract and compare into the output register)
// before it can transfer out. Stall reaches the input only when those three registers
// all hold pending verdicts and the output is stalled.

module multiplicity_timing_event_select (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mtes_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mtes_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [mtes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtes_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [mtes_pkg::CNT_W-1:0]   min_hits_r;
  logic [mtes_pkg::MULT_W-1:0]  pe_multiple_r;
  logic [mtes_pkg::LIMIT_W-1:0] spread_limit_r;

  logic                         accept;
  logic                         ready_b, ready_c, ready_out;
  mtes_pkg::event_t             totals;

  logic                         valid_b_r, valid_b_nxt;
  mtes_pkg::event_t             ev_b_r;

  logic                         valid_c_r, valid_c_nxt;
  logic [mtes_pkg::PROD_W-1:0]  a_c_r, b_c_r;
  logic [mtes_pkg::LIMPROD_W-1:0] lim_c_r;
  logic                         rej_c_r;
  logic [mtes_pkg::CNT_W-1:0]   hits_c_r;

  logic                         out_valid_r, out_valid_nxt;
  mtes_pkg::out_t               out_data_r;

  logic [mtes_pkg::PROD_W-1:0]  diff;
  logic [mtes_pkg::PROD_W+1:0]  spread;
  mtes_pkg::verdict_t           verdict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hits_r     <= mtes_pkg::MIN_HITS_RST;
      pe_multiple_r  <= mtes_pkg::PE_MULTIPLE_RST;
      spread_limit_r <= mtes_pkg::SPREAD_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (mtes_pkg::cfg_index_t'(cfg_index))
        mtes_pkg::CFG_MIN_HITS:     min_hits_r     <= cfg_wdata[mtes_pkg::CNT_W-1:0];
        mtes_pkg::CFG_PE_MULTIPLE:  pe_multiple_r  <= cfg_wdata[mtes_pkg::MULT_W-1:0];
        mtes_pkg::CFG_SPREAD_LIMIT: spread_limit_r <= cfg_wdata[mtes_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ready_out = !out_valid_r || !out_stall;
  assign ready_c   = !valid_c_r || ready_out;
  assign ready_b   = !valid_b_r || ready_c;
  assign in_stall  = !ready_b;
  assign accept    = in_valid && ready_b;

  mtes_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_data),
    .pe_multiple (pe_multiple_r),
    .totals      (totals)
  );

  always_comb begin
    valid_b_nxt = valid_b_r;
    if (ready_b) begin
      valid_b_nxt = accept && in_data.last_channel;
    end
    valid_c_nxt = valid_c_r;
    if (ready_c) begin
      valid_c_nxt = valid_b_r;
    end
    out_valid_nxt = out_valid_r;
    if (ready_out) begin
      out_valid_nxt = valid_c_r;
    end
  end

  always_comb begin
    diff   = (a_c_r > b_c_r) ? a_c_r - b_c_r : '0;
    spread = {diff, 2'b00};
    if (rej_c_r) begin
      verdict = mtes_pkg::VERDICT_REJECT;
    end else if (spread < (mtes_pkg::PROD_W + 2)'(lim_c_r)) begin
      verdict = mtes_pkg::VERDICT_GOOD;
    end else begin
      verdict = mtes_pkg::VERDICT_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r   <= 1'b0;
      valid_c_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_b_r   <= valid_b_nxt;
      valid_c_r   <= valid_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && accept && in_data.last_channel) begin
      ev_b_r <= totals;
    end
    if (ready_c && valid_b_r) begin
      a_c_r    <= mtes_pkg::PROD_W'(ev_b_r.n) * mtes_pkg::PROD_W'(ev_b_r.s2);
      b_c_r    <= mtes_pkg::PROD_W'(ev_b_r.s1) * mtes_pkg::PROD_W'(ev_b_r.s1);
      lim_c_r  <= mtes_pkg::LIMPROD_W'(spread_limit_r) * mtes_pkg::LIMPROD_W'(ev_b_r.n_sq);
      rej_c_r  <= ev_b_r.hits < min_hits_r;
      hits_c_r <= ev_b_r.hits;
    end
    if (ready_out && valid_c_r) begin
      out_data_r.verdict   <= verdict;
      out_data_r.hit_count <= hits_c_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_non_last_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last_channel |=> !valid_b_r)
    else $error("non-last channel entered the verdict pipeline");

  a_reject_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.verdict == mtes_pkg::VERDICT_REJECT) ==
                     (out_data_r.hit_count < min_hits_r)))
    else $error("verdict disagrees with multiplicity");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> valid_b_r && valid_c_r && out_valid_r)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
